/* rtl/core/pts_pkg.sv */
// shared types and constants of the token scanner
// item structs, character classes and token kinds; no dependencies
package pts_pkg;

    localparam int LINE_BITS_DEF = 16;

    localparam logic [7:0] CH_LPAREN = 8'h28;

    typedef struct packed {
        logic       mode;
        logic [7:0] next_char;
    } t_in;

    typedef struct packed {
        logic [7:0]  text_char;
        logic        has_char;
        logic        token_end;
        logic [2:0]  token_kind;
        logic [15:0] line_number;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        K_SYM     = 3'd0,
        K_NUM     = 3'd1,
        K_FLOAT   = 3'd2,
        K_STR     = 3'd3,
        K_INVALID = 3'd4,
        K_EOF     = 3'd5,
        K_UNEXP   = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        C_SPACE,
        C_NL,
        C_LPAREN,
        C_LT,
        C_GT,
        C_COLON,
        C_EQ,
        C_STAR,
        C_RPAREN,
        C_DOT,
        C_SYM1,
        C_ALPHA,
        C_DIGIT,
        C_QUOTE,
        C_OTHER
    } t_class;

    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
        t_class     cls;
    } t_item;

endpackage

/* rtl/core/pascal_like_token_scanner.sv */
// top level of the token scanner: front end, item queue and back end
// depends on pts_pkg, pts_front, pts_back
//
// channel | dir | handshake             | payload
// in      | in  | i_in_valid/o_in_ready | i_in  (t_in: mode, next_char)
// out     | out | o_out_valid/i_out_ready | o_out (t_out: token result)
//
// one item per cycle while the result queue has two free entries
// an item's two results enter the result queue together and leave it one at a time
// rate is set by the single scanner state register updated once per item
// synchronous active-low reset returns to the start state with line count 1
// either side may stall; the item queue and four-entry result queue absorb it
module pascal_like_token_scanner import pts_pkg::*; #(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic  head_valid;
    t_item head;
    logic  pop;

    pts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    pts_back #(
        .LINE_BITS (LINE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .i_item      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/core/pts_front.sv */
// front end: accepts input items, classifies the character, two-entry item queue
// depends on pts_pkg
module pts_front import pts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in,
    output logic  o_head_valid,
    output t_item o_head,
    input  logic  i_pop
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    t_item              r_q [QDEPTH];
    logic [QAW-1:0]     r_wp, r_rp;
    logic [QAW:0]       r_cnt;
    logic               push, pop;
    t_item              item;

    function automatic t_class classify(input logic [7:0] c);
        t_class k;
        if (c inside {8'h20, 8'h09, 8'h0D})      k = C_SPACE;
        else if (c == 8'h0A)                     k = C_NL;
        else if (c == 8'h28)                     k = C_LPAREN;
        else if (c == 8'h3C)                     k = C_LT;
        else if (c == 8'h3E)                     k = C_GT;
        else if (c == 8'h3A)                     k = C_COLON;
        else if (c == 8'h3D)                     k = C_EQ;
        else if (c == 8'h2A)                     k = C_STAR;
        else if (c == 8'h29)                     k = C_RPAREN;
        else if (c == 8'h2E)                     k = C_DOT;
        else if (c inside {8'h2C, 8'h3B, 8'h2B, 8'h2D, 8'h2F, 8'h25}) k = C_SYM1;
        else if (c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F})     k = C_ALPHA;
        else if (c inside {[8'h30:8'h39]})       k = C_DIGIT;
        else if (c == 8'h27)                     k = C_QUOTE;
        else                                     k = C_OTHER;
        return k;
    endfunction

    assign item.eoi = i_in.mode;
    assign item.ch  = i_in.next_char;
    assign item.cls = classify(i_in.next_char);

    assign o_in_ready   = (r_cnt != (QAW+1)'(QDEPTH));
    assign push         = i_in_valid && o_in_ready;
    assign o_head_valid = (r_cnt != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

/* rtl/core/pts_back.sv */
// back end: scanner state machine, line count and result queue
// depends on pts_pkg
module pts_back import pts_pkg::*; #(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_out  o_out
);

    localparam int OQ_DEPTH = 4;
    localparam int OAW      = $clog2(OQ_DEPTH);

    typedef enum logic [3:0] {
        ST_START, ST_LPAREN, ST_COMMENT, ST_STAR, ST_LT, ST_GT, ST_COLON,
        ST_IDENT, ST_NUM, ST_FRAC, ST_STRING
    } t_state;

    typedef struct packed {
        logic       v;
        logic       has;
        logic [7:0] ch;
        logic       tok_end;
        t_kind      kind;
    } t_emit;

    t_state             r_state, n_state;
    logic [LINE_BITS-1:0] r_line;
    t_emit              e1, e2;
    logic               redo, nl, fire, pop_out;
    t_out               res0, res1;
    logic [1:0]         n_push;
    t_out               r_buf [OQ_DEPTH];
    logic [OAW-1:0]     r_wp, r_rp;
    logic [OAW:0]       r_cnt;
    logic               eoi;
    t_class             cls;
    logic [7:0]         ch;

    function automatic t_emit mk(input logic has, input logic [7:0] c,
                                 input logic e, input t_kind k);
        t_emit r;
        r.v       = 1'b1;
        r.has     = has;
        r.ch      = has ? c : 8'h00;
        r.tok_end = e;
        r.kind    = e ? k : K_SYM;
        return r;
    endfunction

    function automatic t_out pack_res(input t_emit e, input logic [15:0] ln,
                                      input logic lst);
        t_out r;
        r.text_char   = e.ch;
        r.has_char    = e.has;
        r.token_end   = e.tok_end;
        r.token_kind  = e.kind;
        r.line_number = ln;
        r.last        = lst;
        return r;
    endfunction

    assign eoi = i_item.eoi;
    assign cls = i_item.cls;
    assign ch  = i_item.ch;

    always_comb begin
        e1      = '0;
        e2      = '0;
        n_state = r_state;
        redo    = 1'b0;
        nl      = 1'b0;
        case (r_state)
            ST_LPAREN: begin
                n_state = ST_START;
                if (eoi) begin
                    e1 = mk(1'b1, CH_LPAREN, 1'b1, K_UNEXP);
                end else if (cls == C_STAR) begin
                    n_state = ST_COMMENT;
                end else begin
                    e1   = mk(1'b1, CH_LPAREN, 1'b1, K_SYM);
                    redo = 1'b1;
                end
            end
            ST_COMMENT, ST_STAR: begin
                if (eoi) begin
                    e1      = mk(1'b0, ch, 1'b1, K_EOF);
                    n_state = ST_START;
                end else if (cls == C_STAR) begin
                    n_state = ST_STAR;
                end else if (cls == C_RPAREN && r_state == ST_STAR) begin
                    n_state = ST_START;
                end else begin
                    nl      = (cls == C_NL);
                    n_state = ST_COMMENT;
                end
            end
            ST_LT, ST_GT, ST_COLON: begin
                n_state = ST_START;
                if (eoi) begin
                    e1 = mk(1'b0, ch, 1'b1, K_UNEXP);
                end else if (cls == C_EQ || (cls == C_GT && r_state == ST_LT)) begin
                    e1 = mk(1'b1, ch, 1'b1, K_SYM);
                end else begin
                    e1   = mk(1'b0, ch, 1'b1, K_SYM);
                    redo = 1'b1;
                end
            end
            ST_IDENT: begin
                if (!eoi && (cls == C_ALPHA || cls == C_DIGIT)) begin
                    e1 = mk(1'b1, ch, 1'b0, K_SYM);
                end else begin
                    e1   = mk(1'b0, ch, 1'b1, K_SYM);
                    redo = 1'b1;
                end
            end
            ST_NUM: begin
                if (!eoi && cls == C_DIGIT) begin
                    e1 = mk(1'b1, ch, 1'b0, K_SYM);
                end else if (!eoi && cls == C_DOT) begin
                    e1      = mk(1'b1, ch, 1'b0, K_SYM);
                    n_state = ST_FRAC;
                end else begin
                    e1   = mk(1'b0, ch, 1'b1, K_NUM);
                    redo = 1'b1;
                end
            end
            ST_FRAC: begin
                if (!eoi && cls == C_DIGIT) begin
                    e1 = mk(1'b1, ch, 1'b0, K_SYM);
                end else begin
                    e1   = mk(1'b0, ch, 1'b1, K_FLOAT);
                    redo = 1'b1;
                end
            end
            ST_STRING: begin
                if (eoi) begin
                    e1      = mk(1'b0, ch, 1'b1, K_UNEXP);
                    n_state = ST_START;
                end else if (cls == C_QUOTE) begin
                    e1      = mk(1'b0, ch, 1'b1, K_STR);
                    n_state = ST_START;
                end else begin
                    e1 = mk(1'b1, ch, 1'b0, K_SYM);
                end
            end
            default: begin
                redo = 1'b1;
            end
        endcase

        // start state, also reprocessing of a character that closed a token
        if (redo) begin
            n_state = ST_START;
            if (eoi) begin
                e2 = mk(1'b0, ch, 1'b1, K_EOF);
            end else begin
                case (cls)
                    C_SPACE:  ;
                    C_NL:     nl = 1'b1;
                    C_LPAREN: n_state = ST_LPAREN;
                    C_LT: begin
                        e2      = mk(1'b1, ch, 1'b0, K_SYM);
                        n_state = ST_LT;
                    end
                    C_GT: begin
                        e2      = mk(1'b1, ch, 1'b0, K_SYM);
                        n_state = ST_GT;
                    end
                    C_COLON: begin
                        e2      = mk(1'b1, ch, 1'b0, K_SYM);
                        n_state = ST_COLON;
                    end
                    C_EQ, C_STAR, C_RPAREN, C_DOT, C_SYM1: begin
                        e2 = mk(1'b1, ch, 1'b1, K_SYM);
                    end
                    C_ALPHA: begin
                        e2      = mk(1'b1, ch, 1'b0, K_SYM);
                        n_state = ST_IDENT;
                    end
                    C_DIGIT: begin
                        e2      = mk(1'b1, ch, 1'b0, K_SYM);
                        n_state = ST_NUM;
                    end
                    C_QUOTE:  n_state = ST_STRING;
                    default: begin
                        e2 = mk(1'b1, ch, 1'b1, K_INVALID);
                    end
                endcase
            end
        end
    end

    // results always carry the line count from before this item
    always_comb begin
        res0   = pack_res(e1, 16'(r_line), 1'b1);
        res1   = pack_res(e2, 16'(r_line), 1'b1);
        n_push = 2'd0;
        if (e1.v && e2.v) begin
            res0.last = 1'b0;
            n_push    = 2'd2;
        end else if (e1.v) begin
            n_push = 2'd1;
        end else if (e2.v) begin
            res0   = res1;
            n_push = 2'd1;
        end
    end

    assign fire        = i_valid && (r_cnt <= (OAW+1)'(OQ_DEPTH - 2));
    assign o_pop       = fire;
    assign o_out_valid = (r_cnt != '0);
    assign pop_out     = o_out_valid && i_out_ready;
    assign o_out       = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (fire && n_push != 2'd0) begin
            r_buf[r_wp] <= res0;
        end
        if (fire && n_push == 2'd2) begin
            r_buf[OAW'(r_wp + 1'b1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_line  <= LINE_BITS'(1);
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            if (fire) begin
                r_state <= n_state;
                if (nl && !(&r_line)) begin
                    r_line <= r_line + 1'b1;
                end
                r_wp <= r_wp + OAW'(fire ? n_push : 2'd0);
            end
            if (pop_out) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OAW+1)'(fire ? n_push : 2'd0) - (OAW+1)'(pop_out);
        end
    end

endmodule

/* rtl/core/pts_checker.sv */
// port-level checks of the token scanner and the bind to the top level
// depends on pts_pkg and pascal_like_token_scanner
module pts_checker import pts_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("stalled result item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item valid after reset");

    a_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.token_end |-> o_out.token_kind == K_SYM)
        else $error("token kind set without token end");

    a_text_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.has_char |-> o_out.text_char == 8'h00)
        else $error("text character set without has_char");

endmodule

bind pascal_like_token_scanner pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
